FILE: rtl/core/ipdd_pkg.sv
// package for the ir pulse distance decoder
// holds default widths, timing tolerances, csr indexes and the phase encoding
// no dependencies
`timescale 1ns / 1ps

package ipdd_pkg;

   // default widths for the top level parameters
   localparam int unsigned TIME_WIDTH_DEF = 16;
   localparam int unsigned CODE_WIDTH_DEF = 32;

   // fixed field widths
   localparam int unsigned OUT_WIDTH      = 32;
   localparam int unsigned COUNT_WIDTH    = 6;
   localparam int unsigned CSR_IDX_WIDTH  = 3;

   // match tolerance: absolute ticks, and fraction of the reference
   localparam int unsigned ABS_TOL        = 100;
   localparam int unsigned REL_DIV        = 3;

   // reset values of the bit count registers
   localparam logic [COUNT_WIDTH-1:0] FRAME_BITS_RESET = COUNT_WIDTH'(32);
   localparam logic [COUNT_WIDTH-1:0] BIT_LIMIT_RESET  = COUNT_WIDTH'(32);

   // csr register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_MARK_TIME       = 3'd0,
      CSR_ONE_PAUSE_TIME  = 3'd1,
      CSR_ZERO_PAUSE_TIME = 3'd2,
      CSR_FRAME_BITS      = 3'd3,
      CSR_BIT_LIMIT       = 3'd4
   } csr_index_type;

   // decoder phase, one-hot
   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_MARKED = 3'b010,
      PH_PAUSED = 3'b100
   } phase_type;

endpackage

FILE: rtl/core/ipdd_req_if.sv
// interval input channel: level and duration of one measured interval
// depends on ipdd_pkg
`timescale 1ns / 1ps

interface ipdd_req_if #(
   parameter int unsigned TIME_WIDTH = ipdd_pkg::TIME_WIDTH_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic                  level;
   logic [TIME_WIDTH-1:0] duration;

   modport source (output valid, output level, output duration, input ready);
   modport sink   (input valid, input level, input duration, output ready);
endinterface

FILE: rtl/core/ipdd_rsp_if.sv
// result channel: one decoded frame code per beat
// depends on ipdd_pkg
`timescale 1ns / 1ps

interface ipdd_rsp_if ();
   logic                           valid;
   logic                           ready;
   logic [ipdd_pkg::OUT_WIDTH-1:0] code;

   modport source (output valid, output code, input ready);
   modport sink   (input valid, input code, output ready);
endinterface

FILE: rtl/core/ipdd_csr_if.sv
// configuration write channel: register index and write data
// depends on ipdd_pkg
`timescale 1ns / 1ps

interface ipdd_csr_if #(
   parameter int unsigned TIME_WIDTH = ipdd_pkg::TIME_WIDTH_DEF
) ();
   logic                               valid;
   logic                               ready;
   logic [ipdd_pkg::CSR_IDX_WIDTH-1:0] index;
   logic [TIME_WIDTH-1:0]              data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ir_pulse_distance_decoder_top.sv
// ir pulse distance decoder: turns measured mark/pause intervals into frame codes
// depends on ipdd_pkg, ipdd_req_if, ipdd_rsp_if and ipdd_csr_if
`timescale 1ns / 1ps

// Usage
//   req_ch carries one interval per beat: level (1 mark, 0 pause) and its
//   duration in timer ticks. rsp_ch carries one 32-bit code per completed
//   frame, first received bit most significant. csr_ch writes the mark and
//   pause reference times, the frame length and the bit limit; it is always
//   ready and should only be written while the decoder is idle.
//   Timing: an interval is captured in the input register at acceptance and
//   decoded from there once the result register can take it; a finished
//   code is loaded into the result register when its last pause is decoded.
//   Throughput: one interval per cycle while rsp_ch takes codes, set by the
//   single decode step between the input register and the result register.
//   A stalled rsp_ch holds its code; the input register still takes one more
//   beat, after which req_ch.ready drops until the code is taken.
//   Reset (synchronous, active high) empties both registers, returns the
//   decoder to idle and loads the reset register values (times zero, frame
//   length and bit limit 32).

module ir_pulse_distance_decoder_top #(
   parameter int unsigned TIME_WIDTH = ipdd_pkg::TIME_WIDTH_DEF,
   parameter int unsigned CODE_WIDTH = ipdd_pkg::CODE_WIDTH_DEF
) (
   input logic          clock,
   input logic          reset,
   ipdd_req_if.sink     req_ch,
   ipdd_rsp_if.source   rsp_ch,
   ipdd_csr_if.sink     csr_ch
);

   localparam int unsigned CW = ipdd_pkg::COUNT_WIDTH;
   localparam int unsigned OW = ipdd_pkg::OUT_WIDTH;

   // configuration registers
   logic [TIME_WIDTH-1:0] mark_time_ff;
   logic [TIME_WIDTH-1:0] one_pause_time_ff;
   logic [TIME_WIDTH-1:0] zero_pause_time_ff;
   logic [CW-1:0]         frame_bits_ff;
   logic [CW-1:0]         bit_limit_ff;

   // input register
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  in_level_ff;
   logic [TIME_WIDTH-1:0] in_dur_ff;

   // decoder state
   ipdd_pkg::phase_type   phase_ff;
   ipdd_pkg::phase_type   phase_in;
   logic [CW-1:0]         bit_count_ff;
   logic [CW-1:0]         bit_count_in;
   logic [CODE_WIDTH-1:0] shift_ff;
   logic [CODE_WIDTH-1:0] shift_in;

   // result register
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [OW-1:0]         out_code_ff;
   logic [OW-1:0]         out_code_in;

   logic                  advance;
   logic                  out_load;
   logic                  mark_ok;
   logic                  one_ok;
   logic                  zero_ok;
   logic [CODE_WIDTH-1:0] shifted;
   logic [CW:0]           next_count;
   logic [CODE_WIDTH+OW-1:0] code_ext;

   // distance within the absolute tolerance and within a third of the reference
   function automatic logic near_ref(input logic [TIME_WIDTH-1:0] ref_t,
                                     input logic [TIME_WIDTH-1:0] val);
      logic [TIME_WIDTH-1:0] diff;
      logic [TIME_WIDTH+1:0] diff3;
      diff  = (val >= ref_t) ? (val - ref_t) : (ref_t - val);
      diff3 = {2'b00, diff} + {1'b0, diff, 1'b0};
      return (diff <= TIME_WIDTH'(ipdd_pkg::ABS_TOL)) && (diff3 <= {2'b00, ref_t});
   endfunction

   // handshake: decode the held interval when the result register can take it
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready   = !in_valid_ff || advance;
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.code    = out_code_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_time_ff       <= '0;
         one_pause_time_ff  <= '0;
         zero_pause_time_ff <= '0;
         frame_bits_ff      <= ipdd_pkg::FRAME_BITS_RESET;
         bit_limit_ff       <= ipdd_pkg::BIT_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            ipdd_pkg::CSR_MARK_TIME:       mark_time_ff       <= csr_ch.data;
            ipdd_pkg::CSR_ONE_PAUSE_TIME:  one_pause_time_ff  <= csr_ch.data;
            ipdd_pkg::CSR_ZERO_PAUSE_TIME: zero_pause_time_ff <= csr_ch.data;
            ipdd_pkg::CSR_FRAME_BITS:      frame_bits_ff      <= csr_ch.data[CW-1:0];
            ipdd_pkg::CSR_BIT_LIMIT:       bit_limit_ff       <= csr_ch.data[CW-1:0];
            default: ;
         endcase
      end
   end

   // input register capture
   assign in_valid_in = (req_ch.valid && req_ch.ready) ? 1'b1 :
                        (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_level_ff <= req_ch.level;
         in_dur_ff   <= req_ch.duration;
      end
   end

   // interval classification
   assign mark_ok    = near_ref(mark_time_ff, in_dur_ff);
   assign one_ok     = near_ref(one_pause_time_ff, in_dur_ff);
   assign zero_ok    = near_ref(zero_pause_time_ff, in_dur_ff);
   assign shifted    = {shift_ff[CODE_WIDTH-2:0], one_ok};
   assign next_count = {1'b0, bit_count_ff} + (CW+1)'(1);
   assign code_ext   = {{OW{1'b0}}, shifted};

   // next state of the decoder
   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      out_load     = 1'b0;
      out_code_in  = code_ext[OW-1:0];
      if (advance) begin
         case (phase_ff)
            ipdd_pkg::PH_PAUSED: begin
               // any interval closes the bit pause
               phase_in = ipdd_pkg::PH_MARKED;
            end
            ipdd_pkg::PH_MARKED: begin
               phase_in     = ipdd_pkg::PH_IDLE;
               bit_count_in = '0;
               shift_in     = '0;
               if (!in_level_ff && (one_ok || zero_ok)) begin
                  if (next_count == {1'b0, frame_bits_ff}) begin
                     out_load = 1'b1;
                  end else if (next_count <= {1'b0, bit_limit_ff}) begin
                     phase_in     = ipdd_pkg::PH_PAUSED;
                     bit_count_in = next_count[CW-1:0];
                     shift_in     = shifted;
                  end
               end
            end
            default: begin
               // idle: a matching mark opens a frame
               if (in_level_ff && mark_ok) begin
                  phase_in = ipdd_pkg::PH_MARKED;
               end else begin
                  phase_in     = ipdd_pkg::PH_IDLE;
                  bit_count_in = '0;
                  shift_in     = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ipdd_pkg::PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
      end
   end

   // result register
   assign out_valid_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_code_ff <= out_code_in;
      end
   end

   // checks
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ipdd_pkg::PH_IDLE) |-> (bit_count_ff == '0 && shift_ff == '0))
      else $error("idle decoder holds frame state");

   a_paused_from_marked: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ipdd_pkg::PH_PAUSED) |->
         ($past(phase_ff) == ipdd_pkg::PH_MARKED || $past(phase_ff) == ipdd_pkg::PH_PAUSED))
      else $error("bit pause phase entered without a decoded bit");

   a_new_code_from_decode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !$past(out_valid_ff)) |-> $past(advance))
      else $error("code appeared without a decoded interval");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && in_dur_ff == $past(in_dur_ff)))
      else $error("held interval lost while result stalled");

endmodule

FILE: tb/tb_top.sv
// testbench for the ir pulse distance decoder: directed and random interval streams
// predicts every frame code on its own and checks each rsp beat against it
// depends on ipdd_pkg, the three channel interfaces and ir_pulse_distance_decoder_top
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned TW             = ipdd_pkg::TIME_WIDTH_DEF;
   localparam int unsigned CNW            = ipdd_pkg::COUNT_WIDTH;
   localparam int unsigned OUW            = ipdd_pkg::OUT_WIDTH;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned HOLD_CYCLES    = 60;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [TW-1:0]  mark_time;
      logic [TW-1:0]  one_pause_time;
      logic [TW-1:0]  zero_pause_time;
      logic [CNW-1:0] frame_bits;
      logic [CNW-1:0] bit_limit;
   } decoder_cfg_type;

   logic clock = 1'b0;
   logic reset;

   ipdd_req_if req_ch ();
   ipdd_rsp_if rsp_ch ();
   ipdd_csr_if csr_ch ();

   ir_pulse_distance_decoder_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   // predicted decoder state and register copy
   decoder_cfg_type     shadow_cfg = '{'0, '0, '0, ipdd_pkg::FRAME_BITS_RESET,
                                       ipdd_pkg::BIT_LIMIT_RESET};
   ipdd_pkg::phase_type dec_phase  = ipdd_pkg::PH_IDLE;
   logic [CNW-1:0]      dec_count  = '0;
   logic [OUW-1:0]      dec_shift  = '0;
   logic [OUW-1:0]      pending_codes [$];

   int unsigned mismatch_count = 0;
   int unsigned codes_taken    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   int unsigned hold_requests  = 0;
   int unsigned holds_served   = 0;
   int unsigned hold_left      = 0;
   int unsigned quiet_cycles   = 0;
   logic [OUW-1:0] wanted_code;

   function automatic bit within_tolerance(input logic [TW-1:0] nominal,
                                           input logic [TW-1:0] measured);
      int unsigned gap;
      gap = (measured >= nominal) ? measured - nominal : nominal - measured;
      return (gap <= ipdd_pkg::ABS_TOL) && (gap <= nominal / ipdd_pkg::REL_DIV);
   endfunction

   function automatic void drop_frame();
      dec_phase = ipdd_pkg::PH_IDLE;
      dec_count = '0;
      dec_shift = '0;
   endfunction

   // one interval through the predicted decoder; a finished frame queues its code
   function automatic void decode_interval(input logic lvl, input logic [TW-1:0] dur);
      bit          hit_one;
      bit          hit_zero;
      int unsigned next_count;
      hit_one  = within_tolerance(shadow_cfg.one_pause_time, dur);
      hit_zero = within_tolerance(shadow_cfg.zero_pause_time, dur);
      case (dec_phase)
         ipdd_pkg::PH_PAUSED: dec_phase = ipdd_pkg::PH_MARKED;
         ipdd_pkg::PH_MARKED: begin
            if (lvl || !(hit_one || hit_zero)) begin
               drop_frame();
            end else begin
               // the bit is the one match, so an overlap reads as a one
               dec_shift  = {dec_shift[OUW-2:0], hit_one};
               next_count = dec_count + 1;
               if (next_count == shadow_cfg.frame_bits) begin
                  pending_codes.push_back(dec_shift);
                  drop_frame();
               end else if (next_count > shadow_cfg.bit_limit) begin
                  drop_frame();
               end else begin
                  dec_count = CNW'(next_count);
                  dec_phase = ipdd_pkg::PH_PAUSED;
               end
            end
         end
         default: begin
            if (lvl && within_tolerance(shadow_cfg.mark_time, dur))
               dec_phase = ipdd_pkg::PH_MARKED;
            else
               drop_frame();
         end
      endcase
   endfunction

   // accepted interval beats drive the prediction
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         decode_interval(req_ch.level, req_ch.duration);
   end

   // register writes update the copy
   always @(posedge clock) begin
      if (!reset && csr_ch.valid && csr_ch.ready) begin
         case (ipdd_pkg::csr_index_type'(csr_ch.index))
            ipdd_pkg::CSR_MARK_TIME:       shadow_cfg.mark_time       = csr_ch.data;
            ipdd_pkg::CSR_ONE_PAUSE_TIME:  shadow_cfg.one_pause_time  = csr_ch.data;
            ipdd_pkg::CSR_ZERO_PAUSE_TIME: shadow_cfg.zero_pause_time = csr_ch.data;
            ipdd_pkg::CSR_FRAME_BITS:      shadow_cfg.frame_bits      = csr_ch.data[CNW-1:0];
            ipdd_pkg::CSR_BIT_LIMIT:       shadow_cfg.bit_limit       = csr_ch.data[CNW-1:0];
            default: ;
         endcase
      end
   end

   // code beats against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         codes_taken++;
         if (pending_codes.size() == 0) begin
            $display("%0t: code beat with none predicted, expected none, actual %h",
                     $time, rsp_ch.code);
            mismatch_count++;
         end else begin
            wanted_code = pending_codes.pop_front();
            if (rsp_ch.code !== wanted_code) begin
               $display("%0t: code mismatch, expected %h, actual %h",
                        $time, wanted_code, rsp_ch.code);
               mismatch_count++;
            end
         end
      end
   end

   // result side ready: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog on beats of any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one interval beat, with random idle cycles ahead of it
   task automatic send_interval(input logic lvl, input logic [TW-1:0] dur);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.level    <= lvl;
      req_ch.duration <= dur;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop sending, let every predicted code arrive and the pipeline empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input ipdd_pkg::csr_index_type idx, input logic [TW-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic load_setting(input decoder_cfg_type s);
      settle();
      csr_beat(ipdd_pkg::CSR_MARK_TIME, s.mark_time);
      csr_beat(ipdd_pkg::CSR_ONE_PAUSE_TIME, s.one_pause_time);
      csr_beat(ipdd_pkg::CSR_ZERO_PAUSE_TIME, s.zero_pause_time);
      csr_beat(ipdd_pkg::CSR_FRAME_BITS, TW'(s.frame_bits));
      csr_beat(ipdd_pkg::CSR_BIT_LIMIT, TW'(s.bit_limit));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // a duration inside the tolerance window of nominal, or just outside it
   function automatic logic [TW-1:0] timing_sample(input logic [TW-1:0] nominal,
                                                   input bit outside);
      int span;
      int offset;
      int value;
      span = int'(nominal) / int'(ipdd_pkg::REL_DIV);
      if (span > int'(ipdd_pkg::ABS_TOL)) span = int'(ipdd_pkg::ABS_TOL);
      if (outside)
         offset = span + 1 + int'($urandom_range(0, 40));
      else if ($urandom_range(0, 3) == 0)
         offset = span;
      else
         offset = int'($urandom_range(0, span));
      if ($urandom_range(0, 1) == 1) offset = -offset;
      value = int'(nominal) + offset;
      if (value < 0) value = 0;
      if (value > int'({TW{1'b1}})) value = int'({TW{1'b1}});
      return TW'(value);
   endfunction

   function automatic logic [TW-1:0] random_time();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return TW'($urandom_range(1, 400));
         default: return TW'($urandom);
      endcase
   endfunction

   // mostly short frames so codes come often, with the extremes mixed in
   function automatic decoder_cfg_type random_setting();
      decoder_cfg_type s;
      s.mark_time       = random_time();
      s.one_pause_time  = random_time();
      s.zero_pause_time = random_time();
      case ($urandom_range(0, 9))
         0:       s.frame_bits = 6'd1;
         1:       s.frame_bits = 6'd32;
         2:       s.frame_bits = 6'($urandom_range(9, 32));
         default: s.frame_bits = 6'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 4))
         0:       s.bit_limit = 6'd63;
         1:       s.bit_limit = 6'($urandom_range(1, 63));
         default: s.bit_limit = 6'($urandom_range(s.frame_bits, 63));
      endcase
      return s;
   endfunction

   // mark, then pause per bit with a free interval between bits; a few are spoilt
   task automatic send_frame(input decoder_cfg_type s, output int unsigned beats);
      int unsigned span;
      int unsigned n_bits;
      int unsigned roll;
      logic        bit_val;
      logic [TW-1:0] nominal;
      if (s.frame_bits == 0 || 32'(s.frame_bits) > 32'(s.bit_limit) + 1)
         span = 32'(s.bit_limit) + 1;
      else
         span = s.frame_bits;
      n_bits = ($urandom_range(0, 9) == 0) ? $urandom_range(1, span) : span;
      send_interval(1'b1, timing_sample(s.mark_time, $urandom_range(0, 99) < 6));
      beats = 1;
      for (int i = 0; i < n_bits; i++) begin
         if (i != 0) begin
            send_interval(1'($urandom_range(0, 1)), TW'($urandom));
            beats++;
         end
         bit_val = 1'($urandom_range(0, 1));
         nominal = bit_val ? s.one_pause_time : s.zero_pause_time;
         roll    = $urandom_range(0, 99);
         if (roll < 2)
            send_interval(1'b1, timing_sample(nominal, 1'b0));
         else
            send_interval(1'b0, timing_sample(nominal, roll < 5));
         beats++;
      end
   endtask

   // idle pause, mark mismatch, mark where a pause is due, unmatched pause
   task automatic test_idle_drops();
      send_interval(1'b0, '0);
      send_interval(1'b1, TW'(1));
      send_interval(1'b1, '0);
      send_interval(1'b1, '0);
      send_interval(1'b1, '0);
      send_interval(1'b0, '0);
      send_interval(1'b0, '1);
      send_interval(1'b0, TW'(1));
   endtask

   // absolute and relative tolerance edges, one and zero bits
   task automatic test_tolerance();
      load_setting('{TW'(150), TW'(1690), TW'(560), 6'd2, 6'd63});
      send_interval(1'b1, TW'(201));
      send_interval(1'b1, TW'(100));
      send_interval(1'b0, TW'(1790));
      send_interval(1'b1, '1);
      send_interval(1'b0, TW'(460));
      send_interval(1'b1, TW'(99));
      send_interval(1'b1, TW'(200));
      send_interval(1'b0, TW'(1791));
      send_interval(1'b1, TW'(150));
      send_interval(1'b0, TW'(661));
   endtask

   // full-scale references, frame length tested ahead of the limit
   task automatic test_extreme_times();
      load_setting('{'1, '1, '0, 6'd3, 6'd2});
      send_interval(1'b1, TW'(65434));
      send_interval(1'b1, TW'(65435));
      send_interval(1'b0, '1);
      send_interval(1'b1, '0);
      send_interval(1'b0, '0);
      send_interval(1'b0, TW'(5));
      send_interval(1'b0, TW'(65435));
   endtask

   // the frame is dropped once the count passes the limit
   task automatic test_bit_limit();
      load_setting('{TW'(560), TW'(1690), TW'(560), 6'd8, 6'd1});
      send_interval(1'b1, TW'(560));
      send_interval(1'b0, TW'(560));
      send_interval(1'b1, TW'(560));
      send_interval(1'b0, TW'(1690));
   endtask

   // a zero frame length never completes, only the limit ends the frame
   task automatic test_frame_bits_zero();
      load_setting('{TW'(560), TW'(1690), TW'(560), 6'd0, 6'd1});
      send_interval(1'b1, TW'(560));
      send_interval(1'b0, TW'(1690));
      send_interval(1'b0, TW'(9));
      send_interval(1'b0, TW'(560));
   endtask

   // both pause references match, the one wins
   task automatic test_overlapping_pauses();
      load_setting('{TW'(560), TW'(1000), TW'(1000), 6'd1, 6'd63});
      send_interval(1'b1, TW'(560));
      send_interval(1'b0, TW'(1000));
      send_interval(1'b1, TW'(460));
      send_interval(1'b0, TW'(1100));
   endtask

   // one-bit frames against a long result hold-off, so the input backs up
   task automatic test_output_stall();
      load_setting('{TW'(560), TW'(1690), TW'(560), 6'd1, 6'd63});
      hold_requests <= hold_requests + 1;
      repeat (12) begin
         send_interval(1'b1, timing_sample(TW'(560), 1'b0));
         send_interval(1'b0, timing_sample($urandom_range(0, 1) ? TW'(1690) : TW'(560), 1'b0));
      end
   endtask

   // mostly well-formed frames under changing settings, the rest noise
   task automatic test_random_traffic(input int unsigned n_beats, input int unsigned n_codes);
      decoder_cfg_type s;
      int unsigned     sent;
      int unsigned     since_load;
      int unsigned     beats;
      int unsigned     codes_start;
      sent        = 0;
      since_load  = 0;
      codes_start = codes_taken;
      s = random_setting();
      load_setting(s);
      while ((sent < n_beats || codes_taken - codes_start < n_codes) && sent < 4 * n_beats) begin
         if (since_load >= 110) begin
            s = random_setting();
            load_setting(s);
            since_load = 0;
         end
         if ($urandom_range(0, 99) < 80) begin
            send_frame(s, beats);
         end else begin
            beats = $urandom_range(1, 4);
            repeat (beats) send_interval(1'($urandom_range(0, 1)), TW'($urandom));
         end
         sent       += beats;
         since_load += beats;
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.level    = 1'b0;
      req_ch.duration = '0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = ipdd_pkg::CSR_MARK_TIME;
      csr_ch.data     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_idling(20, 51);
      test_idle_drops();
      test_tolerance();
      test_extreme_times();
      test_bit_limit();
      test_frame_bits_zero();
      test_overlapping_pauses();
      test_output_stall();
      test_random_traffic(330, 15);

      set_idling(51, 20);
      test_random_traffic(330, 15);
      set_idling(0, 0);
      test_random_traffic(330, 15);

      settle();
      if (mismatch_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/ipdd_pkg.sv
rtl/core/ipdd_req_if.sv
rtl/core/ipdd_rsp_if.sv
rtl/core/ipdd_csr_if.sv
rtl/core/ir_pulse_distance_decoder_top.sv
tb/tb_top.sv
